### rtl/hsfs_pkg.sv
`timescale 1ns / 1ps

package hsfs_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;          // |point - camera| reaches 2^32 - 1
    localparam int RAD_W     = 68;          // sum of three squares
    localparam int ROOT_W    = 34;
    localparam int SQREM_W   = 37;
    localparam int PROD_W    = 68;          // length times clamped span
    localparam int DIVR_W    = 33;
    localparam int LEN_W     = 48;          // quotient bits that survive the Q16 shift
    localparam int LIMIT_W   = 31;
    localparam int OUT_W     = 17;
    localparam int IDX_W     = 3;
    localparam int SQ_STEPS  = 34;
    localparam int DV_STEPS  = 68;
    localparam int FD_STEPS  = 17;

    localparam logic FUNC_GROUND = 1'b0;
    localparam logic FUNC_DIST   = 1'b1;

    localparam logic [OUT_W-1:0] STRENGTH_FULL = 17'h10000;

    typedef enum logic [IDX_W-1:0] {
        REG_CAMERA_X    = 3'd0,
        REG_CAMERA_Y    = 3'd1,
        REG_CAMERA_Z    = 3'd2,
        REG_SLAB_BOTTOM = 3'd3,
        REG_SLAB_TOP    = 3'd4,
        REG_SLAB_RANGE  = 3'd5,
        REG_FAR_DIST    = 3'd6
    } reg_idx_t;

    // square root stage contents
    typedef struct packed {
        logic                 func;
        logic                 zero;
        logic                 clip;
        logic [ROOT_W-1:0]    hs;
        logic [DIFF_W-1:0]    hd;
        logic [RAD_W-1:0]     rad;
        logic [SQREM_W-1:0]   rem;
        logic [ROOT_W-1:0]    root;
    } sq_t;

    // clip division stage contents
    typedef struct packed {
        logic                 func;
        logic                 zero;
        logic                 clip;
        logic [DIFF_W-1:0]    hd;
        logic [ROOT_W-1:0]    len;
        logic [PROD_W-1:0]    num;
        logic [DIVR_W-1:0]    rem;
        logic [PROD_W-1:0]    quo;
    } dv_t;

    // final ratio division stage contents
    typedef struct packed {
        logic                 zero;
        logic                 sat;
        logic [LIMIT_W-1:0]   dvsr;
        logic [LIMIT_W-1:0]   rem;
        logic [OUT_W-1:0]     low;
        logic [OUT_W-1:0]     quo;
    } fd_t;

endpackage

### rtl/height_slab_fog_strength.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Dir  Transfer when
// input     s_valid s_ready s_func s_pt_x/y/z       in   s_valid & s_ready
// result    m_valid m_ready m_strength              out  m_valid & m_ready
// config    cfg_valid cfg_ready cfg_index cfg_data  in   cfg_valid & cfg_ready
//
// Fully pipelined: one item per cycle unless a stalled result holds the pipe.
// The pipe holds the 34-step square root, the 68-step clip divider and the
// 17-step ratio divider, each one stage per step.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
// A stalled result freezes the whole pipe; s_ready follows !m_valid | m_ready.
module height_slab_fog_strength #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [hsfs_pkg::COORD_W-1:0]  s_pt_x,
    input  logic [hsfs_pkg::COORD_W-1:0]  s_pt_y,
    input  logic [hsfs_pkg::COORD_W-1:0]  s_pt_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hsfs_pkg::OUT_W-1:0]    m_strength,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsfs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [hsfs_pkg::COORD_W-1:0]  cfg_data
);
    import hsfs_pkg::*;

    localparam logic [COORD_W-1:0] TOP_RST   = COORD_W'(64'd400 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0] RANGE_RST = LIMIT_W'(64'd3500 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0] FAR_RST   = LIMIT_W'(64'd20000 << FRAC_BITS);

    // ---------------- configuration registers ----------------
    logic [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg, bot_reg, top_reg;
    logic [LIMIT_W-1:0] range_reg, far_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            bot_reg   <= '0;
            top_reg   <= TOP_RST;
            range_reg <= RANGE_RST;
            far_reg   <= FAR_RST;
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_CAMERA_X:    cam_x_reg <= cfg_data;
                REG_CAMERA_Y:    cam_y_reg <= cfg_data;
                REG_CAMERA_Z:    cam_z_reg <= cfg_data;
                REG_SLAB_BOTTOM: bot_reg   <= cfg_data;
                REG_SLAB_TOP:    top_reg   <= cfg_data;
                REG_SLAB_RANGE:  range_reg <= cfg_data[LIMIT_W-1:0];
                REG_FAR_DIST:    far_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves together; only a held result stops it
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: differences and slab clamp ----------------
    logic signed [DIFF_W-1:0] dx, dy, dz, cy, py, bot, top, c2, p2, span;
    logic above_c, below_c, above_p, below_p;
    logic [DIFF_W-1:0] ax_next, ay_next, az_next, hs_abs;
    logic zero_next, clip_next;

    always_comb begin
        cy  = $signed({cam_y_reg[COORD_W-1], cam_y_reg});
        py  = $signed({s_pt_y[COORD_W-1], s_pt_y});
        bot = $signed({bot_reg[COORD_W-1], bot_reg});
        top = $signed({top_reg[COORD_W-1], top_reg});
        dx  = $signed({s_pt_x[COORD_W-1], s_pt_x}) - $signed({cam_x_reg[COORD_W-1], cam_x_reg});
        dy  = py - cy;
        dz  = $signed({s_pt_z[COORD_W-1], s_pt_z}) - $signed({cam_z_reg[COORD_W-1], cam_z_reg});
        ax_next = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay_next = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        az_next = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        above_c = cy > top;
        below_c = cy < bot;
        above_p = py > top;
        below_p = py < bot;
        // camera end clamped first, top test wins over bottom
        c2 = above_c ? top : (below_c ? bot : cy);
        p2 = above_p ? top : (below_p ? bot : py);
        span   = p2 - c2;
        hs_abs = span[DIFF_W-1] ? DIFF_W'(-span) : DIFF_W'(span);
        zero_next = (s_func == FUNC_GROUND) &&
                    ((below_c && below_p) || (above_c && above_p));
        clip_next = (s_func == FUNC_GROUND) && (dy != '0) &&
                    (above_c || below_c || above_p || below_p);
    end

    logic              s1_v_reg;
    logic [DIFF_W-1:0] s1_ax_reg, s1_ay_reg, s1_az_reg, s1_hd_reg;
    logic [ROOT_W-1:0] s1_hs_reg;
    logic              s1_func_reg, s1_zero_reg, s1_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ax_reg   <= ax_next;
            s1_ay_reg   <= ay_next;
            s1_az_reg   <= az_next;
            s1_hd_reg   <= ay_next;
            s1_hs_reg   <= ROOT_W'(hs_abs);
            s1_func_reg <= s_func;
            s1_zero_reg <= zero_next;
            s1_clip_reg <= clip_next;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic                  s2_v_reg;
    logic [2*DIFF_W-1:0]   s2_qx_reg, s2_qy_reg, s2_qz_reg;
    logic [DIFF_W-1:0]     s2_hd_reg;
    logic [ROOT_W-1:0]     s2_hs_reg;
    logic                  s2_func_reg, s2_zero_reg, s2_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_qx_reg   <= s1_ax_reg * s1_ax_reg;
            s2_qy_reg   <= s1_ay_reg * s1_ay_reg;
            s2_qz_reg   <= s1_az_reg * s1_az_reg;
            s2_hd_reg   <= s1_hd_reg;
            s2_hs_reg   <= s1_hs_reg;
            s2_func_reg <= s1_func_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_clip_reg <= s1_clip_reg;
        end
    end

    // ---------------- stage 3: sum, then square root pipe ----------------
    sq_t  sq_reg   [SQ_STEPS+1];
    logic sq_v_reg [SQ_STEPS+1];
    sq_t  sq_first;

    always_comb begin
        sq_first.func = s2_func_reg;
        sq_first.zero = s2_zero_reg;
        sq_first.clip = s2_clip_reg;
        sq_first.hs   = s2_hs_reg;
        sq_first.hd   = s2_hd_reg;
        sq_first.rad  = RAD_W'(s2_qx_reg) + RAD_W'(s2_qy_reg) + RAD_W'(s2_qz_reg);
        sq_first.rem  = '0;
        sq_first.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_v_reg[0] <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0] <= sq_first;
        end
    end

    // one result bit per stage, two radicand bits consumed
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        sq_t                sq_next;
        logic [SQREM_W-1:0] remx, trial;
        always_comb begin
            remx    = {sq_reg[k].rem[SQREM_W-3:0], sq_reg[k].rad[RAD_W-1 -: 2]};
            trial   = {1'b0, sq_reg[k].root, 2'b01};
            sq_next = sq_reg[k];
            sq_next.rad = {sq_reg[k].rad[RAD_W-3:0], 2'b00};
            if (remx >= trial) begin
                sq_next.rem  = remx - trial;
                sq_next.root = {sq_reg[k].root[ROOT_W-2:0], 1'b1};
            end else begin
                sq_next.rem  = remx;
                sq_next.root = {sq_reg[k].root[ROOT_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[k+1] <= sq_next;
            end
        end
    end

    // ---------------- length times span, in two halves ----------------
    localparam int HALF = ROOT_W / 2;
    sq_t                     sq_last;
    logic                    mp_v_reg;
    logic [ROOT_W+HALF-1:0]  mp_lo_reg, mp_hi_reg;
    logic                    mp_func_reg, mp_zero_reg, mp_clip_reg;
    logic [DIFF_W-1:0]       mp_hd_reg;
    logic [ROOT_W-1:0]       mp_len_reg;

    assign sq_last = sq_reg[SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mp_v_reg <= 1'b0;
        end else if (adv) begin
            mp_v_reg <= sq_v_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mp_lo_reg   <= sq_last.root * sq_last.hs[HALF-1:0];
            mp_hi_reg   <= sq_last.root * sq_last.hs[ROOT_W-1:HALF];
            mp_func_reg <= sq_last.func;
            mp_zero_reg <= sq_last.zero;
            mp_clip_reg <= sq_last.clip;
            mp_hd_reg   <= sq_last.hd;
            mp_len_reg  <= sq_last.root;
        end
    end

    // ---------------- clip divider: product / |dy| ----------------
    dv_t  dv_reg   [DV_STEPS+1];
    logic dv_v_reg [DV_STEPS+1];
    dv_t  dv_first;

    always_comb begin
        dv_first.func = mp_func_reg;
        dv_first.zero = mp_zero_reg;
        dv_first.clip = mp_clip_reg;
        dv_first.hd   = mp_hd_reg;
        dv_first.len  = mp_len_reg;
        dv_first.num  = PROD_W'(mp_lo_reg) + (PROD_W'(mp_hi_reg) << HALF);
        dv_first.rem  = '0;
        dv_first.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= mp_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0] <= dv_first;
        end
    end

    for (genvar j = 0; j < DV_STEPS; j++) begin : g_cdiv
        dv_t               dv_next;
        logic [DIVR_W:0]   remx;
        logic              ge;
        always_comb begin
            remx    = {dv_reg[j].rem, dv_reg[j].num[PROD_W-1]};
            ge      = remx >= {1'b0, dv_reg[j].hd};
            dv_next = dv_reg[j];
            dv_next.num = {dv_reg[j].num[PROD_W-2:0], 1'b0};
            dv_next.quo = {dv_reg[j].quo[PROD_W-2:0], ge};
            dv_next.rem = ge ? DIVR_W'(remx - {1'b0, dv_reg[j].hd}) : remx[DIVR_W-1:0];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    // ---------------- ratio setup: numerator, divisor, saturation limit ----------------
    dv_t                dv_last;
    logic [LEN_W-1:0]   len_eff;
    logic [LIMIT_W-1:0] dsel, dvsr_next;
    logic               r1_v_reg;
    logic [63:0]        r1_n_reg;
    logic [LEN_W-1:0]   r1_lim_reg;
    logic [LIMIT_W-1:0] r1_div_reg;
    logic               r1_zero_reg;

    assign dv_last = dv_reg[DV_STEPS];

    always_comb begin
        // length wraps at 48 bits once shifted into Q16
        len_eff   = dv_last.clip ? dv_last.quo[LEN_W-1:0] : LEN_W'(dv_last.len);
        dsel      = (dv_last.func == FUNC_DIST) ? far_reg : range_reg;
        dvsr_next = (dsel == '0) ? LIMIT_W'(1) : dsel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_v_reg <= 1'b0;
        end else if (adv) begin
            r1_v_reg <= dv_v_reg[DV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_n_reg    <= {len_eff, 16'h0000};
            // 65537 * divisor: smallest numerator that saturates
            r1_lim_reg  <= LEN_W'(dvsr_next) + (LEN_W'(dvsr_next) << 16);
            r1_div_reg  <= dvsr_next;
            r1_zero_reg <= dv_last.zero;
        end
    end

    // ---------------- ratio divider, 17 quotient bits ----------------
    fd_t  fd_reg   [FD_STEPS+1];
    logic fd_v_reg [FD_STEPS+1];
    fd_t  fd_first;

    always_comb begin
        fd_first.zero = r1_zero_reg;
        fd_first.sat  = r1_n_reg >= 64'(r1_lim_reg);
        fd_first.dvsr = r1_div_reg;
        fd_first.rem  = r1_n_reg[LIMIT_W+OUT_W-1:OUT_W];
        fd_first.low  = r1_n_reg[OUT_W-1:0];
        fd_first.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_v_reg[0] <= 1'b0;
        end else if (adv) begin
            fd_v_reg[0] <= r1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fd_reg[0] <= fd_first;
        end
    end

    for (genvar f = 0; f < FD_STEPS; f++) begin : g_fdiv
        fd_t              fd_next;
        logic [LIMIT_W:0] remx;
        logic             ge;
        always_comb begin
            remx    = {fd_reg[f].rem, fd_reg[f].low[OUT_W-1]};
            ge      = remx >= {1'b0, fd_reg[f].dvsr};
            fd_next = fd_reg[f];
            fd_next.low = {fd_reg[f].low[OUT_W-2:0], 1'b0};
            fd_next.quo = {fd_reg[f].quo[OUT_W-2:0], ge};
            fd_next.rem = ge ? LIMIT_W'(remx - {1'b0, fd_reg[f].dvsr}) : remx[LIMIT_W-1:0];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fd_v_reg[f+1] <= 1'b0;
            end else if (adv) begin
                fd_v_reg[f+1] <= fd_v_reg[f];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                fd_reg[f+1] <= fd_next;
            end
        end
    end

    // ---------------- output register ----------------
    fd_t               fd_last;
    logic [OUT_W-1:0]  strength_next;
    logic [OUT_W-1:0]  m_strength_reg;

    assign fd_last = fd_reg[FD_STEPS];

    always_comb begin
        if (fd_last.zero) begin
            strength_next = '0;
        end else if (fd_last.sat) begin
            strength_next = STRENGTH_FULL;
        end else begin
            strength_next = fd_last.quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= fd_v_reg[FD_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_strength_reg <= strength_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_strength = m_strength_reg;

endmodule

### rtl/hsfs_checker.sv
`timescale 1ns / 1ps
module hsfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hsfs_pkg::OUT_W-1:0]    m_strength,
    input logic                          cfg_ready
);
    import hsfs_pkg::*;

    // held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_strength))
        else $error("result changed while stalled");

    // strength never exceeds full fog
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_strength <= STRENGTH_FULL)
        else $error("strength above full scale");

    // input side stalls only behind a held result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready mismatch");

    // configuration is always taken
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind height_slab_fog_strength hsfs_checker u_hsfs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_strength (m_strength),
    .cfg_ready  (cfg_ready)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hsfs_pkg::*;

    localparam int LATENCY   = 127;
    localparam int N_RANDOM  = 1750;
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_LONG = 300;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_func;
    logic [COORD_W-1:0]   s_pt_x;
    logic [COORD_W-1:0]   s_pt_y;
    logic [COORD_W-1:0]   s_pt_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [OUT_W-1:0]     m_strength;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    height_slab_fog_strength u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_pt_x    (s_pt_x),
        .s_pt_y    (s_pt_y),
        .s_pt_z    (s_pt_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_strength(m_strength),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Shadow copy of the fog registers, updated on each config transfer.
    logic signed [31:0] sh_cam_x, sh_cam_y, sh_cam_z, sh_bot, sh_top;
    logic [30:0]        sh_range, sh_far;

    // Strength values still owed by the block, oldest first.
    logic [OUT_W-1:0] strength_q[$];

    int  n_err;
    int  n_in;
    int  n_out;
    int  n_ground_clip;
    int  n_dist_sat;
    bit  no_idle;       // last part of the run: both sides go flat out
    bit  hold_req;      // ask the receiver for one long hold-off
    bit  done_stim;

    // floor(sqrt(v)) for v below 2^68, bit by bit
    function automatic logic [33:0] root_floor(input logic [67:0] v);
        logic [33:0] r;
        logic [67:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = {34'd0, r | (34'd1 << b)};
            if (t * t <= v)
                r = r | (34'd1 << b);
        end
        return r;
    endfunction

    // length is shifted into Q16 in a 64-bit word, so its top bits wrap away
    function automatic logic [OUT_W-1:0] fog_ratio(input logic [67:0] len,
                                                   input logic [30:0] dvs);
        logic [67:0] q;
        logic [67:0] d;
        logic [63:0] n;
        d = (dvs == 0) ? 68'd1 : {37'd0, dvs};
        n = {len[47:0], 16'h0000};
        q = {4'd0, n} / d;
        return (q > 68'd65536) ? STRENGTH_FULL : q[OUT_W-1:0];
    endfunction

    // Expected fog strength for one query point under the current registers.
    function automatic logic [OUT_W-1:0] fog_strength(input logic f,
                                                      input logic signed [31:0] px,
                                                      input logic signed [31:0] py,
                                                      input logic signed [31:0] pz);
        logic signed [33:0] dx, dy, dz, c2, p2, span;
        logic [67:0]        sum, len, hs, hd;
        logic [135:0]       prod;
        bit                 clipped;
        dx  = 34'(px) - 34'(sh_cam_x);
        dy  = 34'(py) - 34'(sh_cam_y);
        dz  = 34'(pz) - 34'(sh_cam_z);
        sum = 68'(dx * dx) + 68'(dy * dy) + 68'(dz * dz);
        len = {34'd0, root_floor(sum)};
        if (f == FUNC_DIST)
            return fog_ratio(len, sh_far);
        if ((sh_cam_y < sh_bot && py < sh_bot) || (sh_cam_y > sh_top && py > sh_top))
            return '0;
        c2 = 34'(sh_cam_y);
        p2 = 34'(py);
        clipped = 0;
        if (sh_cam_y > sh_top) begin
            c2 = 34'(sh_top); clipped = 1;
        end else if (sh_cam_y < sh_bot) begin
            c2 = 34'(sh_bot); clipped = 1;
        end
        if (py > sh_top) begin
            p2 = 34'(sh_top); clipped = 1;
        end else if (py < sh_bot) begin
            p2 = 34'(sh_bot); clipped = 1;
        end
        if (clipped && dy != 0) begin
            span = p2 - c2;
            hs   = (span < 0) ? 68'(-span) : 68'(span);
            hd   = (dy < 0) ? 68'(-dy) : 68'(dy);
            prod = 136'(len) * 136'(hs);
            len  = 68'(prod / 136'(hd));
        end
        return fog_ratio(len, sh_range);
    endfunction

    // One register write; the channel goes idle again before the task returns.
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CAMERA_X:    sh_cam_x = val;
            REG_CAMERA_Y:    sh_cam_y = val;
            REG_CAMERA_Z:    sh_cam_z = val;
            REG_SLAB_BOTTOM: sh_bot   = val;
            REG_SLAB_TOP:    sh_top   = val;
            REG_SLAB_RANGE:  sh_range = val[30:0];
            REG_FAR_DIST:    sh_far   = val[30:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Config writes only when the pipe is empty: wait out every owed result,
    // then the pipe depth so nothing is in flight.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (strength_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Send one query; returns after the input transfer. The expected value
    // is computed at the transfer, so it always sees the current registers.
    task automatic send_query(input logic f, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz,
                              input bit pinned, input logic [OUT_W-1:0] pin_val);
        logic [OUT_W-1:0] want;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_pt_x  <= px;
        s_pt_y  <= py;
        s_pt_z  <= pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = fog_strength(f, px, py, pz);
        if (pinned && want != pin_val) begin
            $display("%0t predictor disagrees with table row: row %0d calc %0d",
                     $time, pin_val, want);
            n_err++;
        end
        strength_q.push_back(pinned ? pin_val : want);
        n_in++;
        if (f == FUNC_DIST && want == STRENGTH_FULL) n_dist_sat++;
        if (f == FUNC_GROUND && want != 0 && want != STRENGTH_FULL) n_ground_clip++;
        // hold valid into the next item unless a gap is chosen there
    endtask

    // Random coordinate: mostly near the slab, sometimes full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1200 << 16)) - (200 << 16));
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 4) != 0);
        end
    end

    initial begin
        hold_req = 0;
        wait (n_in == 400);
        hold_req = 1;
        repeat (HOLD_LONG) @(posedge aclk);
        hold_req = 0;
    end

    // Result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_out++;
            if (strength_q.size() == 0) begin
                $display("%0t unexpected strength transfer: actual %0d", $time, m_strength);
                n_err++;
            end else begin
                logic [OUT_W-1:0] exp_s;
                exp_s = strength_q.pop_front();
                if (m_strength !== exp_s) begin
                    $display("%0t strength: expected %0d actual %0d",
                             $time, exp_s, m_strength);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on any channel
    int idle_cycles;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || done_stim || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("height_slab_fog_strength: mismatch");
            $finish;
        end
    end

    typedef struct {
        logic        f;
        logic [31:0] px, py, pz;
        bit          pinned;
        logic [16:0] val;
    } query_row_t;

    // Directed table under reset registers: camera at origin, slab 0..400,
    // range 3500, far 20000 (all Q16.16).
    query_row_t dir_rows[] = '{
        // point at the camera
        '{FUNC_DIST,   32'd0, 32'd0, 32'd0, 1, 17'd0},
        '{FUNC_GROUND, 32'd0, 32'd0, 32'd0, 1, 17'd0},
        // 20000 units far: exactly full distance fog
        '{FUNC_DIST,   32'd20000 << 16, 32'd0, 32'd0, 1, STRENGTH_FULL},
        // 10000 along x: half
        '{FUNC_DIST,   32'd10000 << 16, 32'd0, 32'd0, 1, 17'd32768},
        // corner extremes: saturate
        '{FUNC_DIST,   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, STRENGTH_FULL},
        '{FUNC_DIST,   32'h80000000, 32'h80000000, 32'h80000000, 1, STRENGTH_FULL},
        // point below the slab bottom: no ground fog (camera sits on bottom -> not below)
        '{FUNC_GROUND, 32'd100 << 16, 32'hffff0000, 32'd0, 0, 17'd0},
        // 1750 along ground inside slab: half
        '{FUNC_GROUND, 32'd1750 << 16, 32'd0, 32'd0, 1, 17'd32768},
        '{FUNC_GROUND, 32'd3500 << 16, 32'd0, 32'd0, 1, STRENGTH_FULL},
        // point straight above the slab: clipped to 400 of 800
        '{FUNC_GROUND, 32'd0, 32'd800 << 16, 32'd0, 0, 17'd0},
        '{FUNC_GROUND, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 17'd0},
        '{FUNC_GROUND, 32'h80000000, 32'h80000000, 32'h80000000, 0, 17'd0},
        '{FUNC_GROUND, 32'h12345678, 32'd200 << 16, 32'hedcba987, 0, 17'd0},
        '{FUNC_DIST,   32'd1, 32'd1, 32'd1, 0, 17'd0}
    };

    initial begin
        int cfg_phase;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_func    = FUNC_GROUND;
        s_pt_x    = '0;
        s_pt_y    = '0;
        s_pt_z    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CAMERA_X;
        cfg_data  = '0;
        no_idle   = 0;
        done_stim = 0;
        n_err = 0; n_in = 0; n_out = 0; n_ground_clip = 0; n_dist_sat = 0;
        sh_cam_x = 0; sh_cam_y = 0; sh_cam_z = 0; sh_bot = 0;
        sh_top   = 32'd400 << 16;
        sh_range = 31'(32'd3500 << 16);
        sh_far   = 31'(32'd20000 << 16);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_query(dir_rows[i].f, dir_rows[i].px, dir_rows[i].py, dir_rows[i].pz,
                       dir_rows[i].pinned, dir_rows[i].val);

        // Inverted slab, camera above and below, tiny divisors.
        drain_pipe();
        reg_write(REG_SLAB_BOTTOM, 32'd400 << 16);
        reg_write(REG_SLAB_TOP, 32'd0);
        reg_write(REG_CAMERA_Y, 32'd200 << 16);
        reg_write(REG_SLAB_RANGE, 32'd0);
        reg_write(REG_FAR_DIST, 32'd0);
        send_query(FUNC_GROUND, 32'd5, 32'd200 << 16, 32'd0, 0, '0);
        send_query(FUNC_GROUND, 32'd0, 32'd0, 32'd0, 0, '0);
        // 200 units from the camera over a divisor of one: full fog
        send_query(FUNC_DIST, 32'd0, 32'd0, 32'd0, 1, STRENGTH_FULL);
        send_query(FUNC_DIST, 32'd1, 32'd200 << 16, 32'd0, 0, '0);

        for (cfg_phase = 0; cfg_phase < 6; cfg_phase++) begin
            drain_pipe();
            case (cfg_phase)
                0: begin
                    reg_write(REG_CAMERA_X, 32'h80000000);
                    reg_write(REG_CAMERA_Y, 32'h7fffffff);
                    reg_write(REG_CAMERA_Z, 32'h7fffffff);
                    reg_write(REG_SLAB_BOTTOM, 32'h80000000);
                    reg_write(REG_SLAB_TOP, 32'h7fffffff);
                    reg_write(REG_SLAB_RANGE, 32'h7fffffff);
                    reg_write(REG_FAR_DIST, 32'h7fffffff);
                end
                5: begin
                    reg_write(REG_CAMERA_X, 32'd0);
                    reg_write(REG_CAMERA_Y, 32'd0);
                    reg_write(REG_CAMERA_Z, 32'd0);
                    reg_write(REG_SLAB_BOTTOM, 32'd0);
                    reg_write(REG_SLAB_TOP, 32'd400 << 16);
                    reg_write(REG_SLAB_RANGE, 32'd3500 << 16);
                    reg_write(REG_FAR_DIST, 32'd20000 << 16);
                end
                default: begin
                    logic signed [31:0] lo_h, hi_h;
                    lo_h = rand_coord();
                    hi_h = rand_coord();
                    if ($urandom_range(0, 5) != 0 && lo_h > hi_h) begin
                        logic signed [31:0] t;
                        t = lo_h; lo_h = hi_h; hi_h = t;
                    end
                    reg_write(REG_CAMERA_X, rand_coord());
                    reg_write(REG_CAMERA_Y, rand_coord());
                    reg_write(REG_CAMERA_Z, rand_coord());
                    reg_write(REG_SLAB_BOTTOM, lo_h);
                    reg_write(REG_SLAB_TOP, hi_h);
                    reg_write(REG_SLAB_RANGE, $urandom_range(0, 3) == 0 ? $urandom
                                               : $urandom_range(1, 5000 << 16));
                    reg_write(REG_FAR_DIST, $urandom_range(0, 3) == 0 ? $urandom
                                             : $urandom_range(1, 5000 << 16));
                end
            endcase
            if (cfg_phase == 5) no_idle = 1;
            repeat (N_RANDOM / 6)
                send_query(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                           rand_coord(), 0, '0);
        end

        s_valid <= 1'b0;
        done_stim = 1;
        fork
            begin
                while (strength_q.size() != 0) @(posedge aclk);
                repeat (LATENCY + 10) @(posedge aclk);
            end
            begin
                repeat (WD_LIMIT) @(posedge aclk);
                if (strength_q.size() != 0) begin
                    $display("height_slab_fog_strength: mismatch");
                    $finish;
                end
                wait (0);
            end
        join_any
        $display("%0d queries, %0d strengths; %0d partial ground, %0d full distance",
                 n_in, n_out, n_ground_clip, n_dist_sat);
        $display("covered reset, extreme, inverted-slab and random register settings");
        if (n_err == 0 && strength_q.size() == 0)
            $display("height_slab_fog_strength: match");
        else
            $display("height_slab_fog_strength: mismatch");
        $finish;
    end

endmodule
